[rtl/lbr_pkg.sv]
package lbr_pkg;

    typedef enum logic [1:0] {
        FN_BOOST = 2'd0,
        FN_ROT_Y = 2'd1,
        FN_ROT_Z = 2'd2,
        FN_BAD   = 2'd3
    } func_t;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_BAD_FUNC  = 2'd1,
        ST_BAD_BOOST = 2'd2,
        ST_SAT       = 2'd3
    } status_t;

    localparam int ANG_FRAC = 30;
    localparam int WIDE     = 72;
    localparam int MW       = 65;

    localparam logic [32:0]        TWO_PI_Q30  = 33'd6746518852;
    localparam logic signed [35:0] PI_S        = 36'sd3373259426;
    localparam logic signed [35:0] TWO_PI_S    = 36'sd6746518852;
    localparam logic signed [35:0] HALF_PI_S   = 36'sd1686629713;
    localparam logic signed [32:0] GAIN_INV    = 33'sd652032874;

    typedef struct packed {
        logic  vld;
        func_t func;
        logic  flip;
    } ctl_t;

    typedef struct packed {
        logic               hit;
        logic signed [31:0] val;
    } sat_t;

    function automatic logic [30:0] atan_q30(input int i);
        logic [30:0] r;
        case (i)
            0:       r = 31'd843314857;
            1:       r = 31'd497837829;
            2:       r = 31'd263043837;
            3:       r = 31'd133525159;
            4:       r = 31'd67021687;
            5:       r = 31'd33543516;
            6:       r = 31'd16775851;
            7:       r = 31'd8388437;
            8:       r = 31'd4194283;
            9:       r = 31'd2097149;
            default: r = (i < 31) ? (31'd1 << (30 - i)) : 31'd0;
        endcase
        return r;
    endfunction

    function automatic sat_t sat32(input logic signed [WIDE-1:0] v);
        sat_t r;
        if (v > WIDE'(32'sh7FFFFFFF))
        begin
            r.hit = 1'b1;
            r.val = 32'sh7FFFFFFF;
        end
        else if (v < -WIDE'(33'sh080000000))
        begin
            r.hit = 1'b1;
            r.val = 32'sh80000000;
        end
        else
        begin
            r.hit = 1'b0;
            r.val = v[31:0];
        end
        return r;
    endfunction

endpackage

[rtl/lbr_cell.sv]
module lbr_cell #(
    parameter int FRAC_BITS     = 16,
    parameter int CORDIC_STAGES = 20,
    parameter int IDX           = 0
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        en,
    input  lbr_pkg::ctl_t               ctl_i,
    input  logic signed [31:0]          prm_i,
    input  logic signed [31:0]          px_i,
    input  logic signed [31:0]          py_i,
    input  logic signed [31:0]          pz_i,
    input  logic signed [31:0]          pe_i,
    input  logic [61-FRAC_BITS:0]       mag_i,
    input  logic                        asgn_i,
    input  logic signed [33:0]          ang_i,
    input  logic signed [32:0]          cx_i,
    input  logic signed [32:0]          cy_i,
    input  logic [30:0]                 rem_i,
    input  logic [32+FRAC_BITS:0]       nq_i,
    input  logic                        nsgn_i,
    output lbr_pkg::ctl_t               ctl_o,
    output logic signed [31:0]          prm_o,
    output logic signed [31:0]          px_o,
    output logic signed [31:0]          py_o,
    output logic signed [31:0]          pz_o,
    output logic signed [31:0]          pe_o,
    output logic [61-FRAC_BITS:0]       mag_o,
    output logic                        asgn_o,
    output logic signed [33:0]          ang_o,
    output logic signed [32:0]          cx_o,
    output logic signed [32:0]          cy_o,
    output logic [30:0]                 rem_o,
    output logic [32+FRAC_BITS:0]       nq_o,
    output logic                        nsgn_o
);
    import lbr_pkg::*;

    localparam int AW  = 62 - FRAC_BITS;
    localparam int RED = 29 - FRAC_BITS;
    localparam int QW  = 33 + FRAC_BITS;
    localparam int K   = (IDX < RED) ? (RED - 1 - IDX) : 0;
    localparam int CI  = (IDX > RED) ? (IDX - RED - 1) : 0;

    localparam logic [AW-1:0] RED_SUB = AW'(TWO_PI_Q30) << K;
    localparam logic [30:0]   ATAN    = atan_q30(CI);

    ctl_t                  ctl_reg,  ctl_next;
    logic [AW-1:0]         mag_reg,  mag_next;
    logic signed [33:0]    ang_reg,  ang_next;
    logic signed [32:0]    cx_reg,   cx_next;
    logic signed [32:0]    cy_reg,   cy_next;
    logic [30:0]           rem_reg,  rem_next;
    logic [QW-1:0]         nq_reg,   nq_next;
    logic signed [31:0]    prm_reg, px_reg, py_reg, pz_reg, pe_reg;
    logic                  asgn_reg, nsgn_reg;

    logic signed [35:0]    r;
    logic signed [32:0]    dx, dy;
    logic [31:0]           rem2;
    logic [31:0]           dvs;

    always_comb
    begin
        ctl_next = ctl_i;
        mag_next = mag_i;
        ang_next = ang_i;
        cx_next  = cx_i;
        cy_next  = cy_i;
        rem_next = rem_i;
        nq_next  = nq_i;
        r        = '0;
        dx       = cy_i >>> CI;
        dy       = cx_i >>> CI;
        rem2     = {rem_i, nq_i[QW-1]};
        dvs      = {1'b0, prm_i[30:0]};

        if (IDX < RED)
        begin
            if (mag_i >= RED_SUB)
                mag_next = mag_i - RED_SUB;
        end

        if (IDX == RED)
        begin
            r = asgn_i ? -$signed({2'b00, mag_i[33:0]}) : $signed({2'b00, mag_i[33:0]});
            if (r > PI_S)
                r = r - TWO_PI_S;
            else if (r < -PI_S)
                r = r + TWO_PI_S;
            ctl_next.flip = 1'b0;
            if (r > HALF_PI_S)
            begin
                r = r - PI_S;
                ctl_next.flip = 1'b1;
            end
            else if (r < -HALF_PI_S)
            begin
                r = r + PI_S;
                ctl_next.flip = 1'b1;
            end
            ang_next = r[33:0];
            cx_next  = GAIN_INV;
            cy_next  = '0;
        end

        if (IDX > RED && CI < CORDIC_STAGES)
        begin
            if (!ang_i[33])
            begin
                cx_next  = cx_i - dx;
                cy_next  = cy_i + dy;
                ang_next = ang_i - $signed({3'b000, ATAN});
            end
            else
            begin
                cx_next  = cx_i + dx;
                cy_next  = cy_i - dy;
                ang_next = ang_i + $signed({3'b000, ATAN});
            end
        end

        if (IDX < QW)
        begin
            if (rem2 >= dvs)
            begin
                rem_next = 31'(rem2 - dvs);
                nq_next  = {nq_i[QW-2:0], 1'b1};
            end
            else
            begin
                rem_next = rem2[30:0];
                nq_next  = {nq_i[QW-2:0], 1'b0};
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            ctl_reg <= '0;
        else if (en)
            ctl_reg <= ctl_next;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            mag_reg  <= mag_next;
            ang_reg  <= ang_next;
            cx_reg   <= cx_next;
            cy_reg   <= cy_next;
            rem_reg  <= rem_next;
            nq_reg   <= nq_next;
            prm_reg  <= prm_i;
            px_reg   <= px_i;
            py_reg   <= py_i;
            pz_reg   <= pz_i;
            pe_reg   <= pe_i;
            asgn_reg <= asgn_i;
            nsgn_reg <= nsgn_i;
        end
    end

    assign ctl_o  = ctl_reg;
    assign prm_o  = prm_reg;
    assign px_o   = px_reg;
    assign py_o   = py_reg;
    assign pz_o   = pz_reg;
    assign pe_o   = pe_reg;
    assign mag_o  = mag_reg;
    assign asgn_o = asgn_reg;
    assign ang_o  = ang_reg;
    assign cx_o   = cx_reg;
    assign cy_o   = cy_reg;
    assign rem_o  = rem_reg;
    assign nq_o   = nq_reg;
    assign nsgn_o = nsgn_reg;

endmodule

[rtl/lbr_out.sv]
module lbr_out #(
    parameter int FRAC_BITS = 16
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        en,
    input  lbr_pkg::ctl_t               ctl_i,
    input  logic signed [31:0]          prm_i,
    input  logic signed [31:0]          px_i,
    input  logic signed [31:0]          py_i,
    input  logic signed [31:0]          pz_i,
    input  logic signed [31:0]          pe_i,
    input  logic signed [32:0]          cx_i,
    input  logic signed [32:0]          cy_i,
    input  logic [32+FRAC_BITS:0]       nq_i,
    input  logic                        nsgn_i,
    output logic                        vld_o,
    output logic signed [31:0]          qx_o,
    output logic signed [31:0]          qy_o,
    output logic signed [31:0]          qz_o,
    output logic signed [31:0]          qe_o,
    output logic [1:0]                  status_o
);
    import lbr_pkg::*;

    localparam int QW = 33 + FRAC_BITS;

    logic signed [32:0]    c, s, sep;
    logic signed [31:0]    ysel;
    logic signed [QW:0]    minus;

    logic                  vld1_reg;
    func_t                 func1_reg;
    logic                  pos1_reg;
    logic signed [MW-1:0]  m0_reg, m1_reg, m2_reg, m3_reg, m4_reg;
    logic signed [QW:0]    minus_reg;
    logic signed [31:0]    px1_reg, py1_reg, pz1_reg, pe1_reg;

    logic signed [WIDE-1:0] plus, w0, w1, w2, w3;
    sat_t                  sa, sb;
    logic signed [31:0]    qx_next, qy_next, qz_next, qe_next;
    status_t               status_next;

    logic                  vld_reg;
    logic signed [31:0]    qx_reg, qy_reg, qz_reg, qe_reg;
    status_t               status_reg;

    always_comb
    begin
        c     = ctl_i.flip ? -cx_i : cx_i;
        s     = ctl_i.flip ? -cy_i : cy_i;
        ysel  = (ctl_i.func == FN_ROT_Y) ? pz_i : py_i;
        sep   = 33'(pe_i) + 33'(pz_i);
        minus = nsgn_i ? -$signed({1'b0, nq_i}) : $signed({1'b0, nq_i});
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld1_reg <= 1'b0;
            vld_reg  <= 1'b0;
        end
        else if (en)
        begin
            vld1_reg <= ctl_i.vld;
            vld_reg  <= vld1_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            func1_reg <= ctl_i.func;
            pos1_reg  <= !prm_i[31] && (prm_i != '0);
            m0_reg    <= c * px_i;
            m1_reg    <= s * ysel;
            m2_reg    <= c * ysel;
            m3_reg    <= s * px_i;
            m4_reg    <= sep * prm_i;
            minus_reg <= minus;
            px1_reg   <= px_i;
            py1_reg   <= py_i;
            pz1_reg   <= pz_i;
            pe1_reg   <= pe_i;
        end
    end

    always_comb
    begin
        qx_next     = px1_reg;
        qy_next     = py1_reg;
        qz_next     = pz1_reg;
        qe_next     = pe1_reg;
        status_next = ST_OK;
        plus        = WIDE'(m4_reg) >>> FRAC_BITS;
        w0          = '0;
        w1          = '0;
        w2          = '0;
        w3          = '0;
        sa          = '0;
        sb          = '0;
        case (func1_reg)
            FN_BOOST:
            begin
                if (!pos1_reg)
                    status_next = ST_BAD_BOOST;
                else
                begin
                    w0      = plus - WIDE'(minus_reg);
                    w1      = plus + WIDE'(minus_reg);
                    sa      = sat32(w0 >>> 1);
                    sb      = sat32(w1 >>> 1);
                    qz_next = sa.val;
                    qe_next = sb.val;
                end
            end
            FN_ROT_Y:
            begin
                w0      = WIDE'(m0_reg) + WIDE'(m1_reg);
                w1      = WIDE'(m2_reg) - WIDE'(m3_reg);
                sa      = sat32(w0 >>> ANG_FRAC);
                sb      = sat32(w1 >>> ANG_FRAC);
                qx_next = sa.val;
                qz_next = sb.val;
            end
            FN_ROT_Z:
            begin
                w2      = WIDE'(m0_reg) - WIDE'(m1_reg);
                w3      = WIDE'(m3_reg) + WIDE'(m2_reg);
                sa      = sat32(w2 >>> ANG_FRAC);
                sb      = sat32(w3 >>> ANG_FRAC);
                qx_next = sa.val;
                qy_next = sb.val;
            end
            default:
                status_next = ST_BAD_FUNC;
        endcase
        if (status_next == ST_OK && (sa.hit || sb.hit))
            status_next = ST_SAT;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            qx_reg     <= qx_next;
            qy_reg     <= qy_next;
            qz_reg     <= qz_next;
            qe_reg     <= qe_next;
            status_reg <= status_next;
        end
    end

    assign vld_o    = vld_reg;
    assign qx_o     = qx_reg;
    assign qy_o     = qy_reg;
    assign qz_o     = qz_reg;
    assign qe_o     = qe_reg;
    assign status_o = status_reg;

endmodule

[rtl/lorentz_boost_or_axis_rotation.sv]
// Four-vector transform: boost along z, or rotation about the y or z axis.
// Input channel: in_valid / in_stall with func, param, px, py, pz, pe.
// Output channel: out_valid / out_stall with qx, qy, qz, qe, status.
// A request is taken when valid is high and stall is low.
// A chain of cells does the work: one restoring divide step per cell for the
// boost, and for rotations angle reduction steps, one fold cell and one CORDIC
// iteration per cell. Two more stages form the products and the saturated sums.
// Throughput is one request per clock while out_stall does not hold the chain.
// All stages advance together; while a result waits under out_stall the whole
// chain holds and in_stall is raised, otherwise a request is taken every cycle,
// also while bubbles drain.
// Reset clears all valid flags; no request is lost or repeated across a stall.
module lorentz_boost_or_axis_rotation #(
    parameter int FRAC_BITS     = 16,
    parameter int CORDIC_STAGES = 20
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic [1:0]         func,
    input  logic signed [31:0] param,
    input  logic signed [31:0] px,
    input  logic signed [31:0] py,
    input  logic signed [31:0] pz,
    input  logic signed [31:0] pe,
    output logic               out_valid,
    input  logic               out_stall,
    output logic signed [31:0] qx,
    output logic signed [31:0] qy,
    output logic signed [31:0] qz,
    output logic signed [31:0] qe,
    output logic [1:0]         status
);
    import lbr_pkg::*;

    localparam int AW  = 62 - FRAC_BITS;
    localparam int QW  = 33 + FRAC_BITS;
    localparam int RN  = 30 - FRAC_BITS + CORDIC_STAGES;
    localparam int N   = (QW > RN) ? QW : RN;

    logic en;

    ctl_t               ctl  [0:N];
    logic signed [31:0] prm  [0:N];
    logic signed [31:0] vx   [0:N];
    logic signed [31:0] vy   [0:N];
    logic signed [31:0] vz   [0:N];
    logic signed [31:0] ve   [0:N];
    logic [AW-1:0]      mag  [0:N];
    logic               asgn [0:N];
    logic signed [33:0] ang  [0:N];
    logic signed [32:0] cx   [0:N];
    logic signed [32:0] cy   [0:N];
    logic [30:0]        rem  [0:N];
    logic [QW-1:0]      nq   [0:N];
    logic               nsgn [0:N];

    logic signed [AW-1:0] a0;
    logic signed [32:0]   dz;
    logic [32:0]          dmag;

    assign en       = !out_valid || !out_stall;
    assign in_stall = !en;

    always_comb
    begin
        a0        = AW'(param) <<< (ANG_FRAC - FRAC_BITS);
        dz        = 33'(pe) - 33'(pz);
        dmag      = dz[32] ? 33'(-dz) : 33'(dz);
        ctl[0].vld  = in_valid;
        ctl[0].func = func_t'(func);
        ctl[0].flip = 1'b0;
        prm[0]    = param;
        vx[0]     = px;
        vy[0]     = py;
        vz[0]     = pz;
        ve[0]     = pe;
        mag[0]    = a0[AW-1] ? AW'(-a0) : AW'(a0);
        asgn[0]   = a0[AW-1];
        ang[0]    = '0;
        cx[0]     = '0;
        cy[0]     = '0;
        rem[0]    = '0;
        nq[0]     = {dmag, {FRAC_BITS{1'b0}}};
        nsgn[0]   = dz[32];
    end

    for (genvar k = 0; k < N; k++)
    begin : g_cell
        lbr_cell #(
            .FRAC_BITS     (FRAC_BITS),
            .CORDIC_STAGES (CORDIC_STAGES),
            .IDX           (k)
        ) u_cell (
            .clk    (clk),
            .rst_n  (rst_n),
            .en     (en),
            .ctl_i  (ctl[k]),
            .prm_i  (prm[k]),
            .px_i   (vx[k]),
            .py_i   (vy[k]),
            .pz_i   (vz[k]),
            .pe_i   (ve[k]),
            .mag_i  (mag[k]),
            .asgn_i (asgn[k]),
            .ang_i  (ang[k]),
            .cx_i   (cx[k]),
            .cy_i   (cy[k]),
            .rem_i  (rem[k]),
            .nq_i   (nq[k]),
            .nsgn_i (nsgn[k]),
            .ctl_o  (ctl[k+1]),
            .prm_o  (prm[k+1]),
            .px_o   (vx[k+1]),
            .py_o   (vy[k+1]),
            .pz_o   (vz[k+1]),
            .pe_o   (ve[k+1]),
            .mag_o  (mag[k+1]),
            .asgn_o (asgn[k+1]),
            .ang_o  (ang[k+1]),
            .cx_o   (cx[k+1]),
            .cy_o   (cy[k+1]),
            .rem_o  (rem[k+1]),
            .nq_o   (nq[k+1]),
            .nsgn_o (nsgn[k+1])
        );
    end

    lbr_out #(
        .FRAC_BITS (FRAC_BITS)
    ) u_out (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (en),
        .ctl_i    (ctl[N]),
        .prm_i    (prm[N]),
        .px_i     (vx[N]),
        .py_i     (vy[N]),
        .pz_i     (vz[N]),
        .pe_i     (ve[N]),
        .cx_i     (cx[N]),
        .cy_i     (cy[N]),
        .nq_i     (nq[N]),
        .nsgn_i   (nsgn[N]),
        .vld_o    (out_valid),
        .qx_o     (qx),
        .qy_o     (qy),
        .qz_o     (qz),
        .qe_o     (qe),
        .status_o (status)
    );

endmodule

[rtl/lbr_chk.sv]
module lbr_chk (
    input logic               clk,
    input logic               rst_n,
    input logic               in_valid,
    input logic               in_stall,
    input logic               out_valid,
    input logic               out_stall,
    input logic signed [31:0] qx,
    input logic signed [31:0] qy,
    input logic signed [31:0] qz,
    input logic signed [31:0] qe,
    input logic [1:0]         status
);
    import lbr_pkg::*;

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(qx) && $stable(qz)
        && $stable(status))
        else $error("stalled result changed");

    a_take: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid |-> !in_stall)
        else $error("request refused with empty output");

    a_sat: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status == ST_SAT |->
        qx == 32'sh7FFFFFFF || qx == 32'sh80000000 ||
        qy == 32'sh7FFFFFFF || qy == 32'sh80000000 ||
        qz == 32'sh7FFFFFFF || qz == 32'sh80000000 ||
        qe == 32'sh7FFFFFFF || qe == 32'sh80000000)
        else $error("saturation status without a clamped component");

endmodule

bind lorentz_boost_or_axis_rotation lbr_chk u_chk (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .qx        (qx),
    .qy        (qy),
    .qz        (qz),
    .qe        (qe),
    .status    (status)
);

[tb/sv/lorentz_boost_or_axis_rotation_tb.sv]
`timescale 1ns / 1ps

module lorentz_boost_or_axis_rotation_tb;
    import lbr_pkg::*;

    localparam int FRAC   = 16;
    localparam int STAGES = 20;
    localparam int DRAIN  = 80;
    localparam int LIMIT  = 400000;

    localparam longint PI_A      = 64'sd3373259426;
    localparam longint HALF_PI_A = 64'sd1686629713;
    localparam longint KINV      = 64'sd652032874;
    localparam int     PI_Q16    = 205887;

    typedef struct {
        logic signed [31:0] x;
        logic signed [31:0] y;
        logic signed [31:0] z;
        logic signed [31:0] e;
        logic [1:0]         st;
    } vec_res_t;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               in_valid = 1'b0;
    logic               in_stall;
    logic [1:0]         func = FN_BOOST;
    logic signed [31:0] param = '0;
    logic signed [31:0] px = '0;
    logic signed [31:0] py = '0;
    logic signed [31:0] pz = '0;
    logic signed [31:0] pe = '0;
    logic               out_valid;
    logic               out_stall = 1'b0;
    logic signed [31:0] qx;
    logic signed [31:0] qy;
    logic signed [31:0] qz;
    logic signed [31:0] qe;
    logic [1:0]         status;

    vec_res_t pending_q[$];
    int       n_err = 0;
    int       n_cyc = 0;
    bit       quiet = 1'b0;
    int       hold_left = 0;

    longint atan_tab[31] = '{
        843314857, 497837829, 263043837, 133525159, 67021687,
        33543516, 16775851, 8388437, 4194283, 2097149,
        1048576, 524288, 262144, 131072, 65536,
        32768, 16384, 8192, 4096, 2048,
        1024, 512, 256, 128, 64,
        32, 16, 8, 4, 2, 1
    };

    lorentz_boost_or_axis_rotation #(
        .FRAC_BITS     (FRAC),
        .CORDIC_STAGES (STAGES)
    ) i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .func      (func),
        .param     (param),
        .px        (px),
        .py        (py),
        .pz        (pz),
        .pe        (pe),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .qx        (qx),
        .qy        (qy),
        .qz        (qz),
        .qe        (qe),
        .status    (status)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    function automatic longint clamp32(input longint v, inout bit hit);
        if (v > 64'sd2147483647)
        begin
            hit = 1'b1;
            return 64'sd2147483647;
        end
        if (v < -64'sd2147483648)
        begin
            hit = 1'b1;
            return -64'sd2147483648;
        end
        return v;
    endfunction

    function automatic vec_res_t transform_vec(input logic [1:0] f, input logic signed [31:0] prm,
                                               input logic signed [31:0] vx,
                                               input logic signed [31:0] vy,
                                               input logic signed [31:0] vz,
                                               input logic signed [31:0] ve);
        vec_res_t r;
        longint   p, x, y, z, e, plus, minus, a, c, s, t, dx, dy;
        bit       hit;
        bit       flip;
        p = prm;
        x = vx;
        y = vy;
        z = vz;
        e = ve;
        hit = 1'b0;
        flip = 1'b0;
        r.x = vx;
        r.y = vy;
        r.z = vz;
        r.e = ve;
        r.st = ST_OK;
        if (f == FN_BAD)
            r.st = ST_BAD_FUNC;
        else if (f == FN_BOOST)
        begin
            if (p <= 0)
                r.st = ST_BAD_BOOST;
            else
            begin
                plus = ((e + z) * p) >>> FRAC;
                minus = ((e - z) * (64'sd1 << FRAC)) / p;
                r.z = 32'(clamp32((plus - minus) >>> 1, hit));
                r.e = 32'(clamp32((plus + minus) >>> 1, hit));
            end
        end
        else
        begin
            a = p * (64'sd1 << (30 - FRAC));
            a = a % (2 * PI_A);
            if (a > PI_A)
                a -= 2 * PI_A;
            if (a < -PI_A)
                a += 2 * PI_A;
            if (a > HALF_PI_A)
            begin
                a -= PI_A;
                flip = 1'b1;
            end
            else if (a < -HALF_PI_A)
            begin
                a += PI_A;
                flip = 1'b1;
            end
            c = KINV;
            s = 0;
            for (int i = 0; i < STAGES && i < 31; i++)
            begin
                dx = s >>> i;
                dy = c >>> i;
                if (a >= 0)
                begin
                    t = c - dx;
                    s = s + dy;
                    c = t;
                    a -= atan_tab[i];
                end
                else
                begin
                    t = c + dx;
                    s = s - dy;
                    c = t;
                    a += atan_tab[i];
                end
            end
            if (flip)
            begin
                c = -c;
                s = -s;
            end
            if (f == FN_ROT_Y)
            begin
                r.x = 32'(clamp32((c * x + s * z) >>> 30, hit));
                r.z = 32'(clamp32((c * z - s * x) >>> 30, hit));
            end
            else
            begin
                r.x = 32'(clamp32((c * x - s * y) >>> 30, hit));
                r.y = 32'(clamp32((s * x + c * y) >>> 30, hit));
            end
        end
        if (r.st == ST_OK && hit)
            r.st = ST_SAT;
        return r;
    endfunction

    task automatic send_req(input logic [1:0] f, input logic signed [31:0] prm,
                            input logic signed [31:0] vx, input logic signed [31:0] vy,
                            input logic signed [31:0] vz, input logic signed [31:0] ve);
        int gap;
        gap = 0;
        if (!quiet && $urandom_range(0, 7) == 0)
            gap = $urandom_range(1, 16);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        func     <= f;
        param    <= prm;
        px       <= vx;
        py       <= vy;
        pz       <= vz;
        pe       <= ve;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        pending_q.push_back(transform_vec(f, prm, vx, vy, vz, ve));
    endtask

    function automatic logic signed [31:0] rnd_comp();
        if ($urandom_range(0, 3) == 0)
            return $urandom;
        return 32'(int'($urandom_range(0, 8388608)) - 4194304);
    endfunction

    always @(posedge clk)
    begin
        if (quiet || !rst_n)
            out_stall <= 1'b0;
        else if (hold_left > 0)
        begin
            hold_left <= hold_left - 1;
            out_stall <= 1'b1;
        end
        else if ($urandom_range(0, 7) == 0)
        begin
            hold_left <= $urandom_range(0, 15);
            out_stall <= 1'b1;
        end
        else
            out_stall <= 1'b0;
    end

    always @(posedge clk)
    begin
        vec_res_t w;
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_q.size() == 0)
            begin
                n_err++;
                if (n_err <= 10)
                    $display("unexpected result x=%h y=%h z=%h e=%h st=%0d",
                             qx, qy, qz, qe, status);
            end
            else
            begin
                w = pending_q.pop_front();
                if (qx !== w.x || qy !== w.y || qz !== w.z || qe !== w.e || status !== w.st)
                begin
                    n_err++;
                    if (n_err <= 10)
                        $display("exp x=%h y=%h z=%h e=%h st=%0d got x=%h y=%h z=%h e=%h st=%0d",
                                 w.x, w.y, w.z, w.e, w.st, qx, qy, qz, qe, status);
                end
            end
        end
    end

    always @(posedge clk)
    begin
        n_cyc++;
        if (n_cyc > LIMIT)
        begin
            $display("lorentz_boost_or_axis_rotation: mismatch");
            $finish;
        end
    end

    task automatic test_pass_through();
        send_req(FN_BAD, 32'sh7FFFFFFF, 32'sh80000000, 32'sh7FFFFFFF, 32'sh80000000,
                 32'sh7FFFFFFF);
        send_req(FN_BAD, 32'sh00010000, 32'sh12345678, -32'sd1, 32'sd0, 32'sh00020000);
        send_req(FN_BOOST, 32'sd0, 32'sh00010000, 32'sh00020000, 32'sh00030000,
                 32'sh00040000);
        send_req(FN_BOOST, -32'sd1, 32'sh7FFFFFFF, 32'sh80000000, 32'sh00010000,
                 32'sh00050000);
        send_req(FN_BOOST, 32'sh80000000, 32'sd5, 32'sd6, 32'sd7, 32'sd8);
    endtask

    task automatic test_boost();
        send_req(FN_BOOST, 32'sh00010000, 32'sd1, 32'sd2, 32'sh00030000, 32'sh00050000);
        send_req(FN_BOOST, 32'sh00020000, 32'sd0, 32'sd0, -32'sh00030000, 32'sh00050000);
        send_req(FN_BOOST, 32'sd1, 32'sd0, 32'sd0, 32'sh00010000, -32'sh00010000);
        send_req(FN_BOOST, 32'sh7FFFFFFF, 32'sd0, 32'sd0, 32'sh7FFFFFFF, 32'sh7FFFFFFF);
        send_req(FN_BOOST, 32'sh7FFFFFFF, 32'sd0, 32'sd0, 32'sh80000000, 32'sh80000000);
        send_req(FN_BOOST, 32'sd3, 32'sd0, 32'sd0, 32'sh80000000, 32'sh7FFFFFFF);
        send_req(FN_BOOST, 32'sh00008000, 32'sd9, 32'sd9, -32'sd7, -32'sd3);
    endtask

    task automatic test_rotations();
        send_req(FN_ROT_Y, 32'sd0, 32'sh00010000, 32'sd0, 32'sh00020000, 32'sd0);
        send_req(FN_ROT_Y, PI_Q16, 32'sh00010000, 32'sd1, 32'sh00020000, 32'sd1);
        send_req(FN_ROT_Y, -PI_Q16, 32'sh7FFFFFFF, 32'sd0, 32'sh7FFFFFFF, 32'sd0);
        send_req(FN_ROT_Y, PI_Q16 / 2, 32'sh80000000, 32'sd0, 32'sh80000000, 32'sd0);
        send_req(FN_ROT_Y, 32'sh7FFFFFFF, 32'sh00030000, 32'sd0, -32'sh00050000, 32'sd0);
        send_req(FN_ROT_Z, 32'sh80000000, 32'sh00030000, 32'sh00040000, 32'sd0, 32'sd0);
        send_req(FN_ROT_Z, PI_Q16 / 4, 32'sh7FFFFFFF, 32'sh7FFFFFFF, 32'sd0, 32'sd0);
        send_req(FN_ROT_Z, -PI_Q16 / 2 - 1, 32'sh80000000, 32'sh7FFFFFFF, 32'sd5, 32'sd6);
        send_req(FN_ROT_Z, 3 * PI_Q16, -32'sh00010000, 32'sh00020000, 32'sd0, 32'sd0);
    endtask

    task automatic test_random();
        logic [1:0]         f;
        logic signed [31:0] prm;
        for (int n = 0; n < 1830; n++)
        begin
            if (n == 1580)
                quiet = 1'b1;
            f = 2'($urandom_range(0, 3));
            if ($urandom_range(0, 4) == 0)
                prm = $urandom;
            else if (f == FN_BOOST)
                prm = $urandom_range(4096, 524288);
            else
                prm = 32'(int'($urandom_range(0, 8 * PI_Q16)) - 4 * PI_Q16);
            send_req(f, prm, rnd_comp(), rnd_comp(), rnd_comp(), rnd_comp());
        end
        in_valid <= 1'b0;
    endtask

    initial
    begin
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_pass_through();
        test_boost();
        test_rotations();
        test_random();
        while (pending_q.size() != 0)
            @(posedge clk);
        repeat (DRAIN) @(posedge clk);
        if (n_err == 0)
            $display("lorentz_boost_or_axis_rotation: match");
        else
            $display("lorentz_boost_or_axis_rotation: mismatch");
        $finish;
    end

endmodule
